FILE: rtl/core/soil_water_bucket_step_top_macros.svh
// Assertion macros for the soil water bucket block.
// Each macro expects clk and rst_n in scope.
`ifndef SOIL_WATER_BUCKET_STEP_TOP_MACROS_SVH
`define SOIL_WATER_BUCKET_STEP_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SWB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swb: implication check failed");

// next-cycle implication
`define SWB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swb: next-cycle check failed");

`else

`define SWB_ASSERT_IMP(lbl, ante, cons)
`define SWB_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/swb_pkg.sv
package swb_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE_FRAC = 17'd65536;

  // config register indexes
  localparam logic [2:0] CFG_CAPACITY = 3'd0;
  localparam logic [2:0] CFG_DEPLETION = 3'd1;
  localparam logic [2:0] CFG_CROP_COEF = 3'd2;
  localparam logic [2:0] CFG_RUNOFF = 3'd3;
  localparam logic [2:0] CFG_INIT_WATER = 3'd4;

  // reset values
  localparam logic [15:0] RST_CAPACITY = 16'd10000;
  localparam logic [15:0] RST_DEPLETION = 16'd32768;
  localparam logic [15:0] RST_CROP_COEF = 16'd16384;

  // Hargreaves constants: 2^32/10 split into integer part and 6/10 remainder
  localparam logic [28:0] RECIP10 = 29'd429496729;
  localparam logic [15:0] RECIP5 = 16'd52429;
  localparam logic [17:0] HARG_K = 18'd201520;
  localparam logic [12:0] S_OFFSET = 13'd356;

  // depletion adjustment, scaled down by 2^14
  localparam logic [11:0] ADJ_DEN = 12'd2500;
  localparam logic signed [35:0] ADJ_BIAS = 36'sd32768000;
  localparam logic signed [35:0] ADJ_LO = 36'sd16384000;
  localparam logic signed [35:0] ADJ_HI = 36'sd131072000;

  // iteration counts
  localparam logic [4:0] SQRT_STEPS = 5'd20;
  localparam logic [4:0] DIV_STEPS = 5'd16;
  localparam logic [39:0] SQRT_BIT0 = 40'h40_0000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RUNOFF, ST_QMUL, ST_QSUM, ST_SQRT, ST_SA, ST_SAR, ST_KLO,
    ST_KHI, ST_ET0, ST_ETC, ST_M, ST_MCLAMP, ST_DIVP, ST_PCAP, ST_DEN,
    ST_KSDEC, ST_DIVK, ST_DEM, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RUNOFF, OP_QMUL, OP_QSUM, OP_SQRT, OP_SA, OP_SAR,
    OP_KLO, OP_KHI, OP_ET0, OP_ETC, OP_M, OP_MCLAMP, OP_DIVSTEP, OP_PCAP,
    OP_DEN, OP_KSDEC, OP_DEM, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

  typedef struct packed {
    logic [14:0] rain_used;
    logic [14:0] runoff;
    logic [14:0] infiltration;
    logic [12:0] reference_et;
    logic [16:0] ks_factor;
    logic [15:0] actual_et;
    logic [15:0] drainage;
    logic [15:0] water_after;
  } result_t;

endpackage

FILE: rtl/core/swb_if.sv
interface swb_in_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] min_temperature;
  logic signed [10:0] max_temperature;
  logic signed [15:0] rainfall;
  logic [12:0]        extraterrestrial_radiation;

  modport source (output valid, min_temperature, max_temperature, rainfall,
                  extraterrestrial_radiation, input ready);
  modport sink (input valid, min_temperature, max_temperature, rainfall,
                extraterrestrial_radiation, output ready);
endinterface

interface swb_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] rain_used;
  logic [14:0] runoff;
  logic [14:0] infiltration;
  logic [12:0] reference_et;
  logic [16:0] ks_factor;
  logic [15:0] actual_et;
  logic [15:0] drainage;
  logic [15:0] water_after;

  modport source (output valid, rain_used, runoff, infiltration, reference_et,
                  ks_factor, actual_et, drainage, water_after,
                  input ready);
  modport sink (input valid, rain_used, runoff, infiltration, reference_et,
                ks_factor, actual_et, drainage, water_after,
                output ready);
endinterface

FILE: rtl/core/swb_ctrl.sv
module swb_ctrl
  import swb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_ready,
  output logic    out_valid
);

  state_t     state_r, state_nxt;
  logic [4:0] count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fin_go;

  // result slot is free or being emptied this cycle
  assign fin_go = !out_valid_r || out_ready;

  // next state and iteration counter
  always_comb begin
    state_nxt = state_r;
    count_nxt = 5'd0;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_RUNOFF;
      ST_RUNOFF: state_nxt = ST_QMUL;
      ST_QMUL:   state_nxt = ST_QSUM;
      ST_QSUM:   state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (count_r == SQRT_STEPS - 5'd1) state_nxt = ST_SA;
        else count_nxt = count_r + 5'd1;
      end
      ST_SA:     state_nxt = ST_SAR;
      ST_SAR:    state_nxt = ST_KLO;
      ST_KLO:    state_nxt = ST_KHI;
      ST_KHI:    state_nxt = ST_ET0;
      ST_ET0:    state_nxt = ST_ETC;
      ST_ETC:    state_nxt = ST_M;
      ST_M:      state_nxt = ST_MCLAMP;
      ST_MCLAMP: state_nxt = ST_DIVP;
      ST_DIVP: begin
        if (count_r == DIV_STEPS - 5'd1) state_nxt = ST_PCAP;
        else count_nxt = count_r + 5'd1;
      end
      ST_PCAP:   state_nxt = ST_DEN;
      ST_DEN:    state_nxt = ST_KSDEC;
      ST_KSDEC:  state_nxt = status.need_div ? ST_DIVK : ST_DEM;
      ST_DIVK: begin
        if (count_r == DIV_STEPS - 5'd1) state_nxt = ST_DEM;
        else count_nxt = count_r + 5'd1;
      end
      ST_DEM:    state_nxt = ST_FIN;
      ST_FIN:    if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath command per state
  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      ST_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_RUNOFF: cmd.op = OP_RUNOFF;
      ST_QMUL:   cmd.op = OP_QMUL;
      ST_QSUM:   cmd.op = OP_QSUM;
      ST_SQRT:   cmd.op = OP_SQRT;
      ST_SA:     cmd.op = OP_SA;
      ST_SAR:    cmd.op = OP_SAR;
      ST_KLO:    cmd.op = OP_KLO;
      ST_KHI:    cmd.op = OP_KHI;
      ST_ET0:    cmd.op = OP_ET0;
      ST_ETC:    cmd.op = OP_ETC;
      ST_M:      cmd.op = OP_M;
      ST_MCLAMP: cmd.op = OP_MCLAMP;
      ST_DIVP:   cmd.op = OP_DIVSTEP;
      ST_PCAP:   cmd.op = OP_PCAP;
      ST_DEN:    cmd.op = OP_DEN;
      ST_KSDEC:  cmd.op = OP_KSDEC;
      ST_DIVK:   cmd.op = OP_DIVSTEP;
      ST_DEM:    cmd.op = OP_DEM;
      ST_FIN:    cmd.op = fin_go ? OP_FIN : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_FIN && fin_go) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/swb_datapath.sv
module swb_datapath
  import swb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic signed [10:0] in_min_temperature,
  input  logic signed [10:0] in_max_temperature,
  input  logic signed [15:0] in_rainfall,
  input  logic [12:0]        in_radiation,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output result_t            result
);

  // configuration and store
  logic [15:0] cap_r, pfrac_r, kc_r, rf_r, store_r;

  // latched day
  logic signed [10:0] tmin_r, tmax_r;
  logic signed [15:0] rain_r;
  logic [12:0]        ra_r;

  // working registers
  logic [63:0] prod_r;
  logic [14:0] runoff_r;
  logic [39:0] n_r, res_r, sq_bit_r;
  logic [44:0] b_r;
  logic [40:0] plo_r;
  logic [12:0] et0_r;
  logic [28:0] etcq_r;
  logic [32:0] dr_r, den_r;
  logic [15:0] dbits_r, dq_r, padj_r;
  logic [31:0] pc_r;
  logic [16:0] ks_r;
  logic        ksdiv_r;
  result_t     result_r;

  // combinational terms
  logic signed [11:0] d;
  logic signed [12:0] s;
  logic [10:0]        dmag;
  logic [14:0]        rain_used;
  logic [14:0]        infil;
  logic               et_ok;
  logic [31:0]        mul_a, mul_b;
  logic [12:0]        d3;
  logic [28:0]        frac_p;
  logic [40:0]        trial;
  logic [63:0]        pfull;
  logic [15:0]        e_full;
  logic signed [35:0] m_raw;
  logic [26:0]        m_cl;
  logic [32:0]        div_sh;
  logic [32:0]        ks_den;
  logic [15:0]        cap_minus_w;
  logic               ks_div_case;
  logic [16:0]        ks_use;
  logic [16:0]        demand, avail, aet, after, kept, drain;

  // day terms
  assign d = {tmax_r[10], tmax_r} - {tmin_r[10], tmin_r};
  assign s = {{2{tmin_r[10]}}, tmin_r} + {{2{tmax_r[10]}}, tmax_r} + $signed(S_OFFSET);
  assign dmag = d[10:0];
  assign et_ok = (d > 12'sd0) && (ra_r != 13'd0) && (s > 13'sd0);
  assign rain_used = rain_r[15] ? 15'd0 : rain_r[14:0];
  assign infil = rain_used - runoff_r;

  // remainder part of d*2^32/10 is floor(3d/5)
  assign d3 = {2'b00, dmag} + {1'b0, dmag, 1'b0};
  assign frac_p = d3 * RECIP5;

  // shared multiplier operands
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.op)
      OP_RUNOFF: begin mul_a = {17'd0, rain_used};      mul_b = {16'd0, rf_r}; end
      OP_QMUL:   begin mul_a = {21'd0, dmag};           mul_b = {3'd0, RECIP10}; end
      OP_SA:     begin mul_a = {20'd0, s[11:0]};        mul_b = {19'd0, ra_r}; end
      OP_SAR:    begin mul_a = {7'd0, prod_r[24:0]};    mul_b = {12'd0, res_r[19:0]}; end
      OP_KLO:    begin mul_a = {9'd0, prod_r[22:0]};    mul_b = {14'd0, HARG_K}; end
      OP_KHI:    begin mul_a = {10'd0, b_r[44:23]};     mul_b = {14'd0, HARG_K}; end
      OP_ETC:    begin mul_a = {19'd0, et0_r};          mul_b = {16'd0, kc_r}; end
      OP_M:      begin mul_a = {16'd0, pfrac_r};        mul_b = {20'd0, ADJ_DEN}; end
      OP_PCAP:   begin mul_a = {16'd0, dq_r};           mul_b = {16'd0, cap_r}; end
      OP_DEN: begin
        mul_a = {16'd0, cap_r};
        mul_b = {15'd0, ONE_FRAC - {1'b0, padj_r}};
      end
      OP_DEM:    begin mul_a = {3'd0, etcq_r};          mul_b = {15'd0, ks_use}; end
      default: ;
    endcase
  end

  // square root trial, rounding of ET0, clamp of adjusted p
  assign trial = {1'b0, res_r} + {1'b0, sq_bit_r};
  assign pfull = {prod_r[40:0], 23'd0} + {23'd0, plo_r} + (64'd1 << 47);
  assign e_full = pfull[63:48];
  assign m_raw = $signed({8'd0, prod_r[27:0]}) + ADJ_BIAS - $signed({5'd0, etcq_r, 2'b00});
  always_comb begin
    if (m_raw < ADJ_LO) m_cl = ADJ_LO[26:0];
    else if (m_raw > ADJ_HI) m_cl = ADJ_HI[26:0];
    else m_cl = m_raw[26:0];
  end

  // restoring division step
  assign div_sh = {dr_r[31:0], dbits_r[15]};

  // stress coefficient decision
  assign ks_den = prod_r[32:0];
  assign cap_minus_w = cap_r - store_r;
  assign ks_div_case = (cap_r != 16'd0) && (store_r < cap_r)
                       && ({cap_minus_w, 16'd0} > pc_r)
                       && ({1'b0, store_r, 16'd0} < ks_den);
  assign status.need_div = ks_div_case;
  assign ks_use = ksdiv_r ? {1'b0, dq_r} : ks_r;

  // water balance at day end
  assign demand = prod_r[46:30];
  assign avail = {1'b0, store_r} + {2'b00, infil};
  assign aet = (demand < avail) ? demand : avail;
  assign after = avail - aet;
  assign kept = (after > {1'b0, cap_r}) ? {1'b0, cap_r} : after;
  assign drain = after - kept;

  always_ff @(posedge clk) begin
    // product held while idle with no day offered or waiting on the result slot
    if (cmd.op != OP_NONE) prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        tmin_r <= in_min_temperature;
        tmax_r <= in_max_temperature;
        rain_r <= in_rainfall;
        ra_r   <= in_radiation;
      end
      OP_QMUL: runoff_r <= prod_r[30:16];
      OP_QSUM: begin
        n_r      <= prod_r[39:0] + {29'd0, frac_p[28:18]};
        res_r    <= 40'd0;
        sq_bit_r <= SQRT_BIT0;
      end
      OP_SQRT: begin
        if ({1'b0, n_r} >= trial) begin
          n_r   <= n_r - trial[39:0];
          res_r <= (res_r >> 1) + sq_bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_KLO: b_r <= prod_r[44:0];
      OP_KHI: plo_r <= prod_r[40:0];
      OP_ET0: begin
        if (!et_ok) et0_r <= 13'd0;
        else if (e_full > 16'd8191) et0_r <= 13'h1FFF;
        else et0_r <= e_full[12:0];
      end
      OP_M: etcq_r <= prod_r[28:0];
      OP_MCLAMP: begin
        dr_r    <= {22'd0, m_cl[26:16]};
        dbits_r <= m_cl[15:0];
        den_r   <= {21'd0, ADJ_DEN};
        dq_r    <= 16'd0;
      end
      OP_DIVSTEP: begin
        if (div_sh >= den_r) begin
          dr_r <= div_sh - den_r;
          dq_r <= {dq_r[14:0], 1'b1};
        end else begin
          dr_r <= div_sh;
          dq_r <= {dq_r[14:0], 1'b0};
        end
        dbits_r <= {dbits_r[14:0], 1'b0};
      end
      OP_PCAP: padj_r <= dq_r;
      OP_DEN: pc_r <= prod_r[31:0];
      OP_KSDEC: begin
        ksdiv_r <= ks_div_case;
        ks_r    <= (cap_r == 16'd0) ? 17'd0 : ONE_FRAC;
        dr_r    <= {1'b0, store_r, 16'd0};
        dbits_r <= 16'd0;
        den_r   <= ks_den;
        dq_r    <= 16'd0;
      end
      OP_FIN: begin
        result_r.rain_used    <= rain_used;
        result_r.runoff       <= runoff_r;
        result_r.infiltration <= infil;
        result_r.reference_et <= et0_r;
        result_r.ks_factor    <= ks_use;
        result_r.actual_et    <= aet[15:0];
        result_r.drainage     <= drain[16] ? 16'hFFFF : drain[15:0];
        result_r.water_after  <= kept[15:0];
      end
      default: ;
    endcase
  end

  // configuration registers and stored water
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= RST_CAPACITY;
      pfrac_r <= RST_DEPLETION;
      kc_r    <= RST_CROP_COEF;
      rf_r    <= 16'd0;
      store_r <= 16'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAPACITY:   cap_r <= cfg_data;
          CFG_DEPLETION:  pfrac_r <= cfg_data;
          CFG_CROP_COEF:  kc_r <= cfg_data;
          CFG_RUNOFF:     rf_r <= cfg_data;
          CFG_INIT_WATER: store_r <= (cfg_data < cap_r) ? cfg_data : cap_r;
          default: ;
        endcase
      end
      if (cmd.op == OP_FIN) store_r <= kept[15:0];
    end
  end

  assign result = result_r;

endmodule

FILE: rtl/core/soil_water_bucket_step_top.sv
// Channel  Dir  Request contents
// in_ch    in   min/max temperature, rainfall, extraterrestrial radiation
// out_ch   out  rain split, reference ET, Ks, actual ET, drainage, store
// cfg_*    in   register write: index, 16-bit data
//
// A day runs from acceptance through 20 square-root iterations and one or two
// 16-step divisions (the second only when Ks needs its own division), plus
// single steps on one shared multiplier.
// A new day is taken only once the previous one has finished; the result
// register lets the next day start while a result waits, and that day stalls
// in its last step until the slot is free.
// Reset is synchronous, active low; no clearing pass is needed.
`include "soil_water_bucket_step_top_macros.svh"

module soil_water_bucket_step_top
  import swb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  swb_in_if.sink       in_ch,
  swb_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cmd_t        cmd;
  status_t     status;
  result_t     result;
  logic [15:0] rain_split_sum;
  logic        rain_split_ok;

  swb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  swb_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_min_temperature (in_ch.min_temperature),
    .in_max_temperature (in_ch.max_temperature),
    .in_rainfall        (in_ch.rainfall),
    .in_radiation       (in_ch.extraterrestrial_radiation),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .result             (result)
  );

  // result payload
  assign out_ch.rain_used    = result.rain_used;
  assign out_ch.runoff       = result.runoff;
  assign out_ch.infiltration = result.infiltration;
  assign out_ch.reference_et = result.reference_et;
  assign out_ch.ks_factor    = result.ks_factor;
  assign out_ch.actual_et    = result.actual_et;
  assign out_ch.drainage     = result.drainage;
  assign out_ch.water_after  = result.water_after;

  // runoff and infiltration add back up to the rain used
  assign rain_split_sum = {1'b0, out_ch.runoff} + {1'b0, out_ch.infiltration};
  assign rain_split_ok  = (rain_split_sum == {1'b0, out_ch.rain_used});

  // checks
  `SWB_ASSERT_NXT(a_single_day, in_ch.valid && in_ch.ready, !in_ch.ready)
  `SWB_ASSERT_IMP(a_ks_range, out_ch.valid, out_ch.ks_factor <= ONE_FRAC)
  `SWB_ASSERT_IMP(a_rain_split, out_ch.valid, rain_split_ok)

endmodule
